// ===== hdl/tria_pkg.sv =====
`timescale 1ns / 1ps

package tria_pkg;

    // default sizes
    localparam int MAX_INTERVALS_DEF = 64;
    localparam int TIME_WIDTH_DEF    = 16;
    localparam int INDEX_WIDTH       = 6;

    // event kinds, in sort order at equal time
    localparam int KIND_WIDTH = 2;
    localparam logic [KIND_WIDTH-1:0] KIND_END   = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_START = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_POINT = 2'd2;

    // operation broadcast to every cell of the sorting chain
    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } chain_ctrl_t;

endpackage

// ===== hdl/tria_if.sv =====
`timescale 1ns / 1ps

// one interval per item
interface tria_interval_if #(
    parameter int TIME_WIDTH = tria_pkg::TIME_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] start_time;
    logic [TIME_WIDTH-1:0] end_time;
    logic                  last_interval;

    modport source (output valid, output start_time, output end_time,
                    output last_interval, input ready);
    modport sink   (input valid, input start_time, input end_time,
                    input last_interval, output ready);
endinterface

// one assignment per item
interface tria_result_if;
    logic                               valid;
    logic                               ready;
    logic [tria_pkg::INDEX_WIDTH-1:0]   interval_index;
    logic                               resource;
    logic                               impossible;
    logic                               last_result;

    modport source (output valid, output interval_index, output resource,
                    output impossible, output last_result, input ready);
    modport sink   (input valid, input interval_index, input resource,
                    input impossible, input last_result, output ready);
endinterface

// ===== hdl/tria_ram.sv =====
`timescale 1ns / 1ps

module tria_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/tria_cell.sv =====
`timescale 1ns / 1ps

module tria_cell #(
    parameter int KEY_WIDTH = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tria_pkg::chain_ctrl_t ctrl,
    input  logic [KEY_WIDTH-1:0]  key_in,
    input  logic                  prev_valid,
    input  logic [KEY_WIDTH-1:0]  prev_key,
    input  logic                  prev_gt,
    input  logic                  next_valid,
    input  logic [KEY_WIDTH-1:0]  next_key,
    output logic                  valid,
    output logic [KEY_WIDTH-1:0]  key,
    output logic                  gt
);

    logic                 valid_reg;
    logic [KEY_WIDTH-1:0] key_reg;

    // an empty cell counts as larger than any key
    assign gt    = !valid_reg || (key_in < key_reg);
    assign valid = valid_reg;
    assign key   = key_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (prev_gt)
            begin
                valid_reg <= prev_valid;
            end
            else if (gt)
            begin
                valid_reg <= 1'b1;
            end
        end
        else if (ctrl.pop)
        begin
            valid_reg <= next_valid;
        end
    end

    // key: shift down on insert above, take new key at its place, shift up on pop
    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            if (prev_gt)
            begin
                key_reg <= prev_key;
            end
            else if (gt)
            begin
                key_reg <= key_in;
            end
        end
        else if (ctrl.pop)
        begin
            key_reg <= next_key;
        end
    end

endmodule

// ===== hdl/two_resource_interval_assigner.sv =====
`timescale 1ns / 1ps

// Splits a set of intervals between two resources. Intervals are taken one
// item per cycle while loading; the last_interval flag, or the MAX_INTERVALS-th
// item, ends the set. Each start event goes straight into a sorted chain of
// 2*MAX_INTERVALS cells at load; after the last item the end events are read
// back from the end-time memory and inserted. The sweep then pops one event
// per cycle from the head of the chain, and the results follow one at a time,
// each through a read state and a write state for the registered read of the
// assignment memory, and held while the output register is full. No item is
// accepted from the last item until the last result is issued. If three
// intervals overlap, a single result with impossible set ends the run. No
// clearing pass follows reset.
module two_resource_interval_assigner #(
    parameter int MAX_INTERVALS = tria_pkg::MAX_INTERVALS_DEF,
    parameter int TIME_WIDTH    = tria_pkg::TIME_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    tria_interval_if.sink   intervals,
    tria_result_if.source   results
);

    localparam int IW     = $clog2(MAX_INTERVALS);
    localparam int CW     = $clog2(MAX_INTERVALS + 1);
    localparam int NCELLS = 2 * MAX_INTERVALS;
    localparam int KW     = TIME_WIDTH + tria_pkg::KIND_WIDTH + IW;

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_ENDS    = 3'd1;
    localparam logic [2:0] ST_SWEEP   = 3'd2;
    localparam logic [2:0] ST_OUT_RD  = 3'd3;
    localparam logic [2:0] ST_OUT_WR  = 3'd4;
    localparam logic [2:0] ST_OUT_BAD = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [1:0]    ov_reg, ov_next;
    logic [1:0]    busy_reg, busy_next;
    logic [IW-1:0] own0_reg, own0_next;

    logic                             out_valid_reg, out_valid_next;
    logic [tria_pkg::INDEX_WIDTH-1:0] out_index_reg, out_index_next;
    logic                             out_res_reg, out_res_next;
    logic                             out_imp_reg, out_imp_next;
    logic                             out_last_reg, out_last_next;

    logic                  in_fire;
    logic                  last_load;
    logic                  slot_free;
    logic                  end_point;
    logic [TIME_WIDTH:0]   end_wr_data;
    logic [TIME_WIDTH:0]   end_rd_data;
    logic                  end_wr_en;
    logic                  asg_wr_en;
    logic                  asg_wr_data;
    logic                  asg_rd_data;

    tria_pkg::chain_ctrl_t ctrl;
    logic [KW-1:0]         key_in;
    logic                  cell_valid [NCELLS];
    logic [KW-1:0]         cell_key   [NCELLS];
    logic                  cell_gt    [NCELLS];

    logic [tria_pkg::KIND_WIDTH-1:0] head_kind;
    logic [IW-1:0]                   head_idx;

    assign in_fire   = intervals.valid && intervals.ready;
    assign last_load = intervals.last_interval || (cnt_reg == CW'(MAX_INTERVALS - 1));
    assign slot_free = !out_valid_reg || results.ready;

    // an interval that ends at or before its start is an instant at its start
    assign end_point   = !(intervals.end_time > intervals.start_time);
    assign end_wr_data = {end_point, end_point ? intervals.start_time : intervals.end_time};

    assign head_kind = cell_key[0][IW +: tria_pkg::KIND_WIDTH];
    assign head_idx  = cell_key[0][IW-1:0];

    // end event store, one entry per interval
    tria_ram #(
        .WIDTH (TIME_WIDTH + 1),
        .DEPTH (MAX_INTERVALS)
    ) u_end_ram (
        .clk     (clk),
        .wr_en   (end_wr_en),
        .wr_addr (cnt_reg[IW-1:0]),
        .wr_data (end_wr_data),
        .rd_addr (rd_cnt_reg[IW-1:0]),
        .rd_data (end_rd_data)
    );

    // resource given to each interval
    tria_ram #(
        .WIDTH (1),
        .DEPTH (MAX_INTERVALS)
    ) u_asg_ram (
        .clk     (clk),
        .wr_en   (asg_wr_en),
        .wr_addr (head_idx),
        .wr_data (asg_wr_data),
        .rd_addr (rd_cnt_reg[IW-1:0]),
        .rd_data (asg_rd_data)
    );

    // sorted chain of events, smallest at cell 0
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        logic          p_valid;
        logic [KW-1:0] p_key;
        logic          p_gt;
        logic          n_valid;
        logic [KW-1:0] n_key;

        if (i == 0)
        begin : g_first
            assign p_valid = 1'b0;
            assign p_key   = '0;
            assign p_gt    = 1'b0;
        end
        else
        begin : g_mid
            assign p_valid = cell_valid[i-1];
            assign p_key   = cell_key[i-1];
            assign p_gt    = cell_gt[i-1];
        end

        if (i == NCELLS - 1)
        begin : g_last
            assign n_valid = 1'b0;
            assign n_key   = '0;
        end
        else
        begin : g_inner
            assign n_valid = cell_valid[i+1];
            assign n_key   = cell_key[i+1];
        end

        tria_cell #(
            .KEY_WIDTH (KW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key_in     (key_in),
            .prev_valid (p_valid),
            .prev_key   (p_key),
            .prev_gt    (p_gt),
            .next_valid (n_valid),
            .next_key   (n_key),
            .valid      (cell_valid[i]),
            .key        (cell_key[i]),
            .gt         (cell_gt[i])
        );
    end

    // sequencer: load, end events, sweep, results
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        ov_next        = ov_reg;
        busy_next      = busy_reg;
        own0_next      = own0_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_index_next = out_index_reg;
        out_res_next   = out_res_reg;
        out_imp_next   = out_imp_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;
        key_in         = {intervals.start_time, tria_pkg::KIND_START, cnt_reg[IW-1:0]};
        end_wr_en      = 1'b0;
        asg_wr_en      = 1'b0;
        asg_wr_data    = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    end_wr_en   = 1'b1;
                    ctrl.insert = 1'b1;
                    if (last_load)
                    begin
                        n_next      = cnt_reg + 1'b1;
                        cnt_next    = '0;
                        rd_cnt_next = '0;
                        state_next  = ST_ENDS;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            ST_ENDS:
            begin
                ctrl.insert = pend_reg;
                key_in = {end_rd_data[TIME_WIDTH-1:0],
                          end_rd_data[TIME_WIDTH] ? tria_pkg::KIND_POINT
                                                  : tria_pkg::KIND_END,
                          pend_idx_reg};
                if (rd_cnt_reg != n_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_cnt_reg[IW-1:0];
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    ov_next    = '0;
                    busy_next  = '0;
                    state_next = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                if (cell_valid[0])
                begin
                    ctrl.pop = 1'b1;
                    if (head_kind == tria_pkg::KIND_START)
                    begin
                        if (ov_reg == 2'd2)
                        begin
                            state_next = ST_OUT_BAD;
                        end
                        else
                        begin
                            ov_next   = ov_reg + 1'b1;
                            asg_wr_en = 1'b1;
                            if (!busy_reg[0])
                            begin
                                busy_next[0] = 1'b1;
                                own0_next    = head_idx;
                                asg_wr_data  = 1'b0;
                            end
                            else
                            begin
                                busy_next[1] = 1'b1;
                                asg_wr_data  = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (ov_reg != 2'd0)
                        begin
                            ov_next = ov_reg - 1'b1;
                        end
                        // free the resource this interval holds
                        if (busy_reg[0] && (own0_reg == head_idx))
                        begin
                            busy_next[0] = 1'b0;
                        end
                        else
                        begin
                            busy_next[1] = 1'b0;
                        end
                    end
                end
                else
                begin
                    rd_cnt_next = '0;
                    state_next  = ST_OUT_RD;
                end
            end

            ST_OUT_RD:
            begin
                state_next = ST_OUT_WR;
            end

            ST_OUT_WR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = tria_pkg::INDEX_WIDTH'(rd_cnt_reg[IW-1:0]);
                    out_res_next   = asg_rd_data;
                    out_imp_next   = 1'b0;
                    out_last_next  = ((rd_cnt_reg + 1'b1) == n_reg);
                    if ((rd_cnt_reg + 1'b1) == n_reg)
                    begin
                        ctrl.clear = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + 1'b1;
                        state_next  = ST_OUT_RD;
                    end
                end
            end

            ST_OUT_BAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = '0;
                    out_res_next   = 1'b0;
                    out_imp_next   = 1'b1;
                    out_last_next  = 1'b1;
                    ctrl.clear     = 1'b1;
                    state_next     = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            ov_reg        <= '0;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            ov_reg        <= ov_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and counters without reset
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        rd_cnt_reg    <= rd_cnt_next;
        pend_idx_reg  <= pend_idx_next;
        own0_reg      <= own0_next;
        out_index_reg <= out_index_next;
        out_res_reg   <= out_res_next;
        out_imp_reg   <= out_imp_next;
        out_last_reg  <= out_last_next;
    end

    assign intervals.ready        = (state_reg == ST_LOAD);
    assign results.valid          = out_valid_reg;
    assign results.interval_index = out_index_reg;
    assign results.resource       = out_res_reg;
    assign results.impossible     = out_imp_reg;
    assign results.last_result    = out_last_reg;

    // checks
    a_ov_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg != 2'd3)
        else $error("overlap count out of range");

    a_busy_ov: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> $countones(busy_reg) == int'(ov_reg))
        else $error("busy resources disagree with overlap count");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && $past(state_reg) == ST_SWEEP && cell_valid[0])
            |-> cell_key[0] > $past(cell_key[0]))
        else $error("events leave the chain out of order");

    a_imp_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_imp_reg) |-> out_last_reg)
        else $error("impossible item not marked last");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !pend_reg)
        else $error("end event pending while loading");

endmodule
